### design/rde_pkg.sv
// Shared types and constants for the repeating decimal expander.
`default_nettype none
package rde_pkg;
    localparam int DW = 12;
    localparam int DENOM_MAX_DEF = 4096;
    localparam int SHOWN_DIGITS_DEF = 50;
    localparam int DIGIT_DEPTH = 64;
    localparam int EPOCH_W = 8;

    localparam logic [2:0] KIND_INT    = 3'd0;
    localparam logic [2:0] KIND_PRE    = 3'd1;
    localparam logic [2:0] KIND_CYCLE  = 3'd2;
    localparam logic [2:0] KIND_TRUNC  = 3'd3;
    localparam logic [2:0] KIND_LENGTH = 3'd4;

    typedef struct packed {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
    } frac_t;
endpackage
`default_nettype wire

### design/rde_front.sv
// Front end: takes fraction commands and fixes up the denominator.
`default_nettype none
module rde_front #(
    parameter int DENOM_MAX = rde_pkg::DENOM_MAX_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [rde_pkg::DW-1:0] numerator,
    input  wire logic [rde_pkg::DW-1:0] denominator,
    input  wire logic                 full,
    output logic                      push,
    output rde_pkg::frac_t            item
);
    import rde_pkg::*;

    localparam int DEN_LIM = (DENOM_MAX - 1 < (1 << DW) - 1) ? DENOM_MAX - 1 : (1 << DW) - 1;

    logic [DW-1:0] den_fix;
    logic          busy_reg;

    // A zero denominator acts as one; large ones saturate to DENOM_MAX - 1.
    always_comb
    begin
        if (denominator == '0)
            den_fix = DW'(1);
        else if (32'(denominator) > DEN_LIM)
            den_fix = DW'(DEN_LIM);
        else
            den_fix = denominator;
    end

    // Busy is the queue full flag ORed with a registered copy of it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= full;
    end

    assign busy     = busy_reg | full;
    assign push     = start & ~busy;
    assign item.num = numerator;
    assign item.den = den_fix;
endmodule
`default_nettype wire

### design/rde_queue.sv
// Two-entry queue between the front end and the digit engine.
`default_nettype none
module rde_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  rde_pkg::frac_t wdata,
    output logic          full,
    input  wire logic     pop,
    output logic          valid,
    output rde_pkg::frac_t rdata
);
    import rde_pkg::*;

    frac_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign rdata = slot_reg[rd_ptr_reg];
endmodule
`default_nettype wire

### design/rde_back.sv
// Digit engine: integer division, long division with cycle detection, emission.
`default_nettype none
module rde_back #(
    parameter int DENOM_MAX    = rde_pkg::DENOM_MAX_DEF,
    parameter int SHOWN_DIGITS = rde_pkg::SHOWN_DIGITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid,
    input  rde_pkg::frac_t    item,
    output logic              pop,
    output logic              strobe,
    output logic [2:0]        kind,
    output logic [rde_pkg::DW-1:0] value,
    output logic              last
);
    import rde_pkg::*;

    localparam int AW = $clog2(DENOM_MAX);
    localparam int PW = AW + 1;
    localparam int MW = DW + 4;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_DIV, S_LOOK, S_CHK, S_ERD, S_EOUT, S_ELEN
    } state_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [PW-1:0]      idx;
    } seen_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [DW-1:0]      den_reg;
    logic [DW-1:0]      dvd_reg;
    logic [DW-1:0]      quo_reg;
    logic [DW-1:0]      r_reg;
    logic [3:0]         cnt_reg;
    logic [MW-1:0]      acc_reg;
    logic [MW-1:0]      mult_reg [10];
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      start_reg;
    logic [PW-1:0]      i_reg;
    logic               strobe_reg;
    logic [2:0]         kind_reg;
    logic [DW-1:0]      value_reg;
    logic               last_reg;

    seen_t              seen_mem [DENOM_MAX];
    seen_t              seen_rd_reg;
    logic [3:0]         buf_mem [DIGIT_DEPTH];
    logic [3:0]         buf_rd_reg;

    logic [DW:0]        trial;
    logic [MW-1:0]      ten_r;
    logic [3:0]         digit;
    logic [MW-1:0]      sub_val;
    logic               hit;
    logic [PW-1:0]      pos_inc;
    logic               seen_we;
    logic [AW-1:0]      seen_waddr;
    seen_t              seen_wdata;
    logic               buf_we;

    // One restoring division step for the integer part.
    assign trial = {r_reg, dvd_reg[DW-1]};

    // Next digit: count the multiples of the denominator that fit in ten times r.
    always_comb
    begin
        ten_r = (MW'(r_reg) << 3) + (MW'(r_reg) << 1);
        digit = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (mult_reg[k] <= ten_r)
                digit = 4'(k);
        end
        sub_val = mult_reg[digit];
    end

    assign hit     = seen_rd_reg.epoch == epoch_reg;
    assign pos_inc = pos_reg + PW'(1);

    // Seen store control: clearing pass or a fresh remainder.
    always_comb
    begin
        seen_we          = (state_reg == S_CLR) || (state_reg == S_CHK && !hit);
        seen_waddr       = (state_reg == S_CLR) ? clr_addr_reg : AW'(r_reg);
        seen_wdata.epoch = (state_reg == S_CLR) ? '0 : epoch_reg;
        seen_wdata.idx   = (state_reg == S_CLR) ? '0 : pos_inc;
        buf_we           = (state_reg == S_CHK) && !hit && (32'(pos_inc) < DIGIT_DEPTH);
    end

    // Seen store, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_waddr] <= seen_wdata;
        seen_rd_reg <= seen_mem[AW'(r_reg)];
    end

    // Digit buffer by position.
    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[6'(pos_inc)] <= digit;
        buf_rd_reg <= buf_mem[6'(i_reg)];
    end

    assign pop = valid && (state_reg == S_IDLE);

    // Sequencer with registered result outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_addr_reg <= '0;
            epoch_reg    <= EPOCH_W'(1);
            strobe_reg   <= 1'b0;
            kind_reg     <= KIND_INT;
            value_reg    <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    if (clr_addr_reg == AW'(DENOM_MAX - 1))
                    begin
                        clr_addr_reg <= '0;
                        epoch_reg    <= EPOCH_W'(1);
                        state_reg    <= S_IDLE;
                    end
                    else
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                end
                S_IDLE:
                begin
                    if (valid)
                    begin
                        den_reg     <= item.den;
                        dvd_reg     <= item.num;
                        quo_reg     <= '0;
                        r_reg       <= '0;
                        cnt_reg     <= '0;
                        acc_reg     <= '0;
                        mult_reg[0] <= '0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // Division step, and one more multiple of the denominator.
                    dvd_reg <= dvd_reg << 1;
                    if (trial >= {1'b0, den_reg})
                    begin
                        r_reg   <= DW'(trial - {1'b0, den_reg});
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg   <= DW'(trial);
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    if (cnt_reg < 4'd9)
                    begin
                        acc_reg                 <= acc_reg + MW'(den_reg);
                        mult_reg[cnt_reg + 4'd1] <= acc_reg + MW'(den_reg);
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(DW - 1))
                    begin
                        strobe_reg <= 1'b1;
                        kind_reg   <= KIND_INT;
                        value_reg  <= (trial >= {1'b0, den_reg}) ?
                                      {quo_reg[DW-2:0], 1'b1} : {quo_reg[DW-2:0], 1'b0};
                        pos_reg    <= '0;
                        state_reg  <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (hit)
                    begin
                        start_reg <= seen_rd_reg.idx - PW'(1);
                        i_reg     <= PW'(1);
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        pos_reg   <= pos_inc;
                        r_reg     <= DW'(ten_r - sub_val);
                        state_reg <= S_LOOK;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EOUT;
                end
                S_EOUT:
                begin
                    strobe_reg <= 1'b1;
                    if (i_reg <= start_reg)
                    begin
                        kind_reg  <= KIND_PRE;
                        value_reg <= (32'(i_reg) < DIGIT_DEPTH) ? DW'(buf_rd_reg) : '0;
                        i_reg     <= i_reg + PW'(1);
                        state_reg <= S_ERD;
                    end
                    else if (i_reg <= pos_reg)
                    begin
                        if (32'(i_reg) > SHOWN_DIGITS || 32'(i_reg) >= DIGIT_DEPTH)
                        begin
                            kind_reg  <= KIND_TRUNC;
                            value_reg <= '0;
                            state_reg <= S_ELEN;
                        end
                        else
                        begin
                            kind_reg  <= KIND_CYCLE;
                            value_reg <= DW'(buf_rd_reg);
                            i_reg     <= i_reg + PW'(1);
                            state_reg <= S_ERD;
                        end
                    end
                    else
                    begin
                        kind_reg  <= KIND_LENGTH;
                        value_reg <= DW'(pos_reg - start_reg);
                        last_reg  <= 1'b1;
                        if (epoch_reg == '1)
                            state_reg <= S_CLR;
                        else
                        begin
                            epoch_reg <= epoch_reg + EPOCH_W'(1);
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_ELEN:
                begin
                    strobe_reg <= 1'b1;
                    kind_reg   <= KIND_LENGTH;
                    value_reg  <= DW'(pos_reg - start_reg);
                    last_reg   <= 1'b1;
                    if (epoch_reg == '1)
                        state_reg <= S_CLR;
                    else
                    begin
                        epoch_reg <= epoch_reg + EPOCH_W'(1);
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign kind   = kind_reg;
    assign value  = value_reg;
    assign last   = last_reg;
endmodule
`default_nettype wire

### design/repeating_decimal_expander_top.sv
// Top level of the repeating decimal expander.
// A fraction is taken when start is high and busy is low; up to two fractions
// wait in a queue while the engine works. Each fraction gives its integer part
// from a restoring division, then runs long division with one S_LOOK/S_CHK
// pass per fractional digit (up to denominator digits), then one S_ERD/S_EOUT
// pass per emitted digit from the digit buffer, ending with the cycle length
// item flagged by last. Results appear for one cycle each with strobe high and
// must be taken then. After reset, and after every 255th fraction, the seen
// store is cleared at all DENOM_MAX addresses while queued fractions wait.
`default_nettype none
module repeating_decimal_expander_top #(
    parameter int DENOM_MAX    = rde_pkg::DENOM_MAX_DEF,
    parameter int SHOWN_DIGITS = rde_pkg::SHOWN_DIGITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [rde_pkg::DW-1:0] numerator,
    input  wire logic [rde_pkg::DW-1:0] denominator,
    output logic                        strobe,
    output logic [2:0]                  kind,
    output logic [rde_pkg::DW-1:0]      value,
    output logic                        last
);
    import rde_pkg::*;

    logic  full;
    logic  push;
    logic  pop;
    logic  q_valid;
    frac_t f_item;
    frac_t q_item;

    rde_front #(.DENOM_MAX(DENOM_MAX)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .numerator(numerator), .denominator(denominator),
        .full(full), .push(push), .item(f_item)
    );

    rde_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(f_item), .full(full),
        .pop(pop), .valid(q_valid), .rdata(q_item)
    );

    rde_back #(.DENOM_MAX(DENOM_MAX), .SHOWN_DIGITS(SHOWN_DIGITS)) u_back (
        .clk(clk), .rst_n(rst_n), .valid(q_valid), .item(q_item), .pop(pop),
        .strobe(strobe), .kind(kind), .value(value), .last(last)
    );
endmodule
`default_nettype wire
